>>> sv/assert_macros.svh
// Assertion macros shared by the volume field blend evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define VFBE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vfbe assertion failed");

// Next-cycle implication, sampled on clk, idle during reset.
`define VFBE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vfbe assertion failed");

`endif

>>> sv/vfbe_pkg.sv
// Shared constants, types and saturation helper for the volume field blend evaluator.
package vfbe_pkg;

  localparam int MAX_SHAPES_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int WORDS_PER_SHAPE = 20;
  localparam int COUNT_W         = 6;
  localparam int SAT_W           = 68;

  // Word offsets inside one shape record
  localparam logic [4:0] W_CTL   = 5'd0;
  localparam logic [4:0] W_VAL   = 5'd1;
  localparam logic [4:0] W_MAT   = 5'd2;
  localparam logic [4:0] W_SCALE = 5'd14;
  localparam logic [4:0] W_BIAS  = 5'd17;
  localparam logic [4:0] W_LAST  = 5'd19;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [2:0] MODE_ADD  = 3'd0;
  localparam logic [2:0] MODE_SUB  = 3'd1;
  localparam logic [2:0] MODE_MUL  = 3'd2;
  localparam logic [2:0] MODE_DIV  = 3'd3;
  localparam logic [2:0] MODE_MAX  = 3'd4;
  localparam logic [2:0] MODE_MIN  = 3'd5;
  localparam logic [2:0] MODE_SET  = 3'd6;
  localparam logic [2:0] MODE_KEEP = 3'd7;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SAT  = 2'd1;
  localparam logic [1:0] STAT_DIV0 = 2'd2;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] val;
  } sat_res_t;

  function automatic sat_res_t sat32(input logic signed [SAT_W-1:0] v);
    sat_res_t r;
    if (v > SAT_W'(64'sh7FFF_FFFF)) begin
      r.hit = 1'b1;
      r.val = 32'sh7FFF_FFFF;
    end else if (v < -SAT_W'(64'sh8000_0000)) begin
      r.hit = 1'b1;
      r.val = -32'sh7FFF_FFFF - 32'sd1;
    end else begin
      r.hit = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> sv/vfbe_ifs.sv
// Valid/ready channel interfaces for input items, results and configuration writes.
interface vfbe_in_if import vfbe_pkg::*;;
  logic               valid;
  logic               ready;
  logic               op;
  logic [4:0]         shape_index;
  logic [4:0]         word_index;
  logic signed [31:0] word_value;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] initial_value;

  modport source (output valid, op, shape_index, word_index, word_value,
                  pos_x, pos_y, pos_z, initial_value, input ready);
  modport sink   (input valid, op, shape_index, word_index, word_value,
                  pos_x, pos_y, pos_z, initial_value, output ready);
endinterface

interface vfbe_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] field_value;
  logic [1:0]         status;

  modport source (output valid, field_value, status, input ready);
  modport sink   (input valid, field_value, status, output ready);
endinterface

interface vfbe_cfg_if import vfbe_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> sv/volume_field_blend_evaluator.sv
// Volume field blend evaluator: shape table plus one shared multiplier under a sequencer.
// A load item writes one table word. An evaluate item visits each shape in turn; a sphere
// runs a bit-serial square root and a divide blend runs a bit-serial divider, while a
// missed shape ends sooner.
// One item at a time; the next item is taken while a result waits in the output register.
// Reset (synchronous, rst_n low) clears the sequencer, output valid and shape_count.
`include "assert_macros.svh"

module volume_field_blend_evaluator import vfbe_pkg::*; #(
  parameter int MAX_SHAPES = MAX_SHAPES_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  vfbe_in_if.sink    in_ch,
  vfbe_out_if.source out_ch,
  vfbe_cfg_if.sink   cfg_ch
);

  localparam int F     = FRAC_BITS;
  localparam int DEPTH = MAX_SHAPES * WORDS_PER_SHAPE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(MAX_SHAPES + 1);
  localparam int PW    = 66;
  localparam int SW    = PW - F;
  localparam int RW    = 2 * F + 2;
  localparam int DW    = 32 + F;
  localparam int IT_W  = $clog2(DW);
  localparam logic signed [SAT_W-1:0] ONE_W = {{(SAT_W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic [63:0] SQ_LIM = 64'd1 << (2 * F);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_CTL    = 5'd1;
  localparam logic [4:0] ST_TR     = 5'd2;
  localparam logic [4:0] ST_TD     = 5'd3;
  localparam logic [4:0] ST_MUL    = 5'd4;
  localparam logic [4:0] ST_ACC    = 5'd5;
  localparam logic [4:0] ST_GEOM   = 5'd6;
  localparam logic [4:0] ST_SQ     = 5'd7;
  localparam logic [4:0] ST_SQA    = 5'd8;
  localparam logic [4:0] ST_SQCHK  = 5'd9;
  localparam logic [4:0] ST_SQRT   = 5'd10;
  localparam logic [4:0] ST_AM     = 5'd11;
  localparam logic [4:0] ST_AB     = 5'd12;
  localparam logic [4:0] ST_BM     = 5'd13;
  localparam logic [4:0] ST_BB     = 5'd14;
  localparam logic [4:0] ST_BA     = 5'd15;
  localparam logic [4:0] ST_BAA    = 5'd16;
  localparam logic [4:0] ST_VAL    = 5'd17;
  localparam logic [4:0] ST_BLEND  = 5'd18;
  localparam logic [4:0] ST_BMUL   = 5'd19;
  localparam logic [4:0] ST_DIV    = 5'd20;
  localparam logic [4:0] ST_DIVF   = 5'd21;
  localparam logic [4:0] ST_INTERP = 5'd22;
  localparam logic [4:0] ST_IACC   = 5'd23;
  localparam logic [4:0] ST_NEXT   = 5'd24;
  localparam logic [4:0] ST_DONE   = 5'd25;

  function automatic logic [F:0] clamp_unit(input logic signed [SAT_W-1:0] v);
    logic [F:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > ONE_W) begin
      r = ONE_W[F:0];
    end else begin
      r = v[F:0];
    end
    return r;
  endfunction

  logic [4:0]         state_r, state_nxt;
  logic [COUNT_W-1:0] count_r;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_val_r, out_val_nxt;
  logic [1:0]         out_st_r, out_st_nxt;

  logic signed [31:0] pos_r [3];
  logic signed [31:0] pos_nxt [3];
  logic signed [31:0] loc_r [3];
  logic signed [31:0] loc_nxt [3];
  logic signed [32:0] loc_abs [3];
  logic signed [31:0] cur_r, cur_nxt;
  logic signed [31:0] nv_r, nv_nxt;
  logic signed [SW+1:0] acc_r, acc_nxt;
  logic signed [PW-1:0] prod_r;
  logic [63:0]        sq_r, sq_nxt;
  logic [3:0]         ctl_r, ctl_nxt;
  logic [F:0]         alpha_r, alpha_nxt;
  logic [F:0]         tmp_r, tmp_nxt;
  logic               sat_r, sat_nxt;
  logic               div0_r, div0_nxt;
  logic [1:0]         row_r, row_nxt;
  logic [1:0]         col_r, col_nxt;
  logic [CNT_W-1:0]   s_r, s_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [AW-1:0]      base_r, base_nxt;
  logic [RW-1:0]      rad_r, rad_nxt;
  logic [F:0]         root_r, root_nxt;
  logic [F+2:0]       rem_r, rem_nxt;
  logic [IT_W-1:0]    it_r, it_nxt;
  logic [DW-1:0]      dvd_r, dvd_nxt;
  logic [DW-1:0]      quo_r, quo_nxt;
  logic [31:0]        dvs_r, dvs_nxt;
  logic [31:0]        drem_r, drem_nxt;
  logic               neg_r, neg_nxt;

  logic signed [32:0] mul_a, mul_b;
  logic signed [SW-1:0] prod_sh;
  logic [4:0]         rd_off;
  logic [AW-1:0]      rd_addr;
  logic [31:0]        rd_data;
  logic signed [31:0] rd_s;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               in_xfer;
  logic               out_xfer;

  assign in_xfer       = in_ch.valid && in_ch.ready;
  assign out_xfer      = out_ch.valid && out_ch.ready;
  assign in_ch.ready   = (state_r == ST_IDLE);
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.field_value = out_val_r;
  assign out_ch.status      = out_st_r;

  assign prod_sh = $signed(prod_r[PW-1:F]);
  assign rd_s    = $signed(rd_data);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      loc_abs[i] = (loc_r[i] < 0) ? -33'(loc_r[i]) : 33'(loc_r[i]);
    end
  end

  // Table write on a load transfer with a legal address
  assign wr_en   = in_xfer && (in_ch.op == OP_LOAD) &&
                   (32'(in_ch.shape_index) < MAX_SHAPES) && (in_ch.word_index <= W_LAST);
  assign wr_addr = AW'(int'(in_ch.shape_index) * WORDS_PER_SHAPE + int'(in_ch.word_index));

  always_comb begin
    unique case (state_r) inside
      ST_CTL:   rd_off = W_CTL;
      ST_TR:    rd_off = W_MAT + 5'd3 + {1'b0, row_r, 2'b00};
      ST_TD:    rd_off = W_MAT + {1'b0, row_r, 2'b00};
      ST_ACC:   rd_off = W_MAT + {1'b0, row_r, 2'b00} + 5'(col_r) + 5'd1;
      ST_GEOM,
      ST_SQCHK,
      ST_SQRT:  rd_off = W_SCALE;
      ST_AM:    rd_off = W_BIAS;
      ST_BM:    rd_off = W_BIAS + 5'(col_r);
      ST_BAA:   rd_off = W_SCALE + 5'(col_r) + 5'd1;
      ST_VAL:   rd_off = W_VAL;
      default:  rd_off = W_CTL;
    endcase
  end

  assign rd_addr = base_r + AW'(rd_off);

  vfbe_shape_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_ch.word_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MUL: begin
        mul_a = 33'(rd_s);
        mul_b = 33'(pos_r[col_r]);
      end
      ST_SQ: begin
        mul_a = 33'(loc_r[col_r]);
        mul_b = 33'(loc_r[col_r]);
      end
      ST_AM: begin
        mul_a = 33'(root_r);
        mul_b = 33'(rd_s);
      end
      ST_BM: begin
        mul_a = loc_abs[col_r];
        mul_b = 33'(rd_s);
      end
      ST_BA: begin
        mul_a = 33'(alpha_r);
        mul_b = 33'(tmp_r);
      end
      ST_BLEND: begin
        mul_a = 33'(cur_r);
        mul_b = 33'(rd_s);
      end
      ST_INTERP: begin
        mul_a = 33'(nv_r) - 33'(cur_r);
        mul_b = 33'(alpha_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    sat_res_t           sres;
    logic signed [SW+1:0] acc_sum;
    logic [F+4:0]       rem2;
    logic [F+4:0]       trial;
    logic [32:0]        drem2;
    logic               ge;
    logic signed [DW:0] qs;
    logic signed [32:0] cabs;
    logic signed [32:0] vabs;

    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    pos_nxt       = pos_r;
    loc_nxt       = loc_r;
    cur_nxt       = cur_r;
    nv_nxt        = nv_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    ctl_nxt       = ctl_r;
    alpha_nxt     = alpha_r;
    tmp_nxt       = tmp_r;
    sat_nxt       = sat_r;
    div0_nxt      = div0_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    s_nxt         = s_r;
    n_nxt         = n_r;
    base_nxt      = base_r;
    rad_nxt       = rad_r;
    root_nxt      = root_r;
    rem_nxt       = rem_r;
    it_nxt        = it_r;
    dvd_nxt       = dvd_r;
    quo_nxt       = quo_r;
    dvs_nxt       = dvs_r;
    drem_nxt      = drem_r;
    neg_nxt       = neg_r;
    sres          = '0;
    acc_sum       = acc_r + (SW+2)'(prod_sh);
    rem2          = {rem_r, rad_r[RW-1:RW-2]};
    trial         = (F+5)'({root_r, 2'b01});
    drem2         = {drem_r, dvd_r[DW-1]};
    ge            = drem2 >= {1'b0, dvs_r};
    qs            = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    cabs          = (cur_r < 0) ? -33'(cur_r) : 33'(cur_r);
    vabs          = (rd_s < 0) ? -33'(rd_s) : 33'(rd_s);

    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_ch.op == OP_EVAL)) begin
          pos_nxt[0] = in_ch.pos_x;
          pos_nxt[1] = in_ch.pos_y;
          pos_nxt[2] = in_ch.pos_z;
          cur_nxt    = in_ch.initial_value;
          sat_nxt    = 1'b0;
          div0_nxt   = 1'b0;
          s_nxt      = '0;
          base_nxt   = '0;
          n_nxt      = (32'(count_r) > MAX_SHAPES) ? CNT_W'(MAX_SHAPES) : CNT_W'(count_r);
          state_nxt  = (count_r == '0) ? ST_DONE : ST_CTL;
        end
      end
      ST_CTL: begin
        row_nxt   = 2'd0;
        state_nxt = ST_TR;
      end
      ST_TR: begin
        if (row_r == 2'd0) begin
          ctl_nxt = rd_data[3:0];
        end
        state_nxt = ST_TD;
      end
      ST_TD: begin
        acc_nxt   = (SW+2)'(rd_s);
        col_nxt   = 2'd0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt = acc_sum;
        if (col_r == 2'd2) begin
          sres            = sat32(SAT_W'(acc_sum));
          loc_nxt[row_r]  = sres.val;
          if (row_r == 2'd2) begin
            state_nxt = ST_GEOM;
          end else begin
            row_nxt   = row_r + 2'd1;
            state_nxt = ST_TR;
          end
        end else begin
          col_nxt   = col_r + 2'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_GEOM: begin
        col_nxt = 2'd0;
        if (!ctl_r[0]) begin
          sq_nxt    = '0;
          state_nxt = ST_SQ;
        end else if ((loc_abs[0] <= 33'(ONE_W)) && (loc_abs[1] <= 33'(ONE_W)) &&
                     (loc_abs[2] <= 33'(ONE_W))) begin
          alpha_nxt = ONE_W[F:0];
          state_nxt = ST_BM;
        end else begin
          state_nxt = ST_NEXT;
        end
      end
      ST_SQ: begin
        state_nxt = ST_SQA;
      end
      ST_SQA: begin
        sq_nxt = sq_r + prod_r[63:0];
        if (col_r == 2'd2) begin
          state_nxt = ST_SQCHK;
        end else begin
          col_nxt   = col_r + 2'd1;
          state_nxt = ST_SQ;
        end
      end
      ST_SQCHK: begin
        if (sq_r > SQ_LIM) begin
          state_nxt = ST_NEXT;
        end else begin
          rad_nxt   = sq_r[RW-1:0];
          root_nxt  = '0;
          rem_nxt   = '0;
          it_nxt    = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        // one result bit per cycle, two radicand bits in
        if (rem2 >= trial) begin
          rem_nxt  = (F+3)'(rem2 - trial);
          root_nxt = {root_r[F-1:0], 1'b1};
        end else begin
          rem_nxt  = rem2[F+2:0];
          root_nxt = {root_r[F-1:0], 1'b0};
        end
        rad_nxt = rad_r << 2;
        it_nxt  = it_r + IT_W'(1);
        if (it_r == IT_W'(F)) begin
          state_nxt = ST_AM;
        end
      end
      ST_AM: begin
        state_nxt = ST_AB;
      end
      ST_AB: begin
        alpha_nxt = clamp_unit(SAT_W'(prod_sh) + SAT_W'(rd_s));
        state_nxt = ST_VAL;
      end
      ST_BM: begin
        state_nxt = ST_BB;
      end
      ST_BB: begin
        tmp_nxt   = clamp_unit(SAT_W'(prod_sh) + SAT_W'(rd_s));
        state_nxt = ST_BA;
      end
      ST_BA: begin
        state_nxt = ST_BAA;
      end
      ST_BAA: begin
        alpha_nxt = prod_sh[F:0];
        if (col_r == 2'd2) begin
          state_nxt = ST_VAL;
        end else begin
          col_nxt   = col_r + 2'd1;
          state_nxt = ST_BM;
        end
      end
      ST_VAL: begin
        state_nxt = ST_BLEND;
      end
      ST_BLEND: begin
        state_nxt = ST_INTERP;
        unique case (ctl_r[3:1])
          MODE_ADD: begin
            sres    = sat32(SAT_W'(cur_r) + SAT_W'(rd_s));
            nv_nxt  = sres.val;
            sat_nxt = sat_r | sres.hit;
          end
          MODE_SUB: begin
            sres    = sat32(SAT_W'(cur_r) - SAT_W'(rd_s));
            nv_nxt  = sres.val;
            sat_nxt = sat_r | sres.hit;
          end
          MODE_MUL: begin
            state_nxt = ST_BMUL;
          end
          MODE_DIV: begin
            if (rd_s == 32'sd0) begin
              div0_nxt = 1'b1;
              nv_nxt   = cur_r;
            end else begin
              dvd_nxt   = {cabs[31:0], {F{1'b0}}};
              dvs_nxt   = vabs[31:0];
              drem_nxt  = '0;
              quo_nxt   = '0;
              neg_nxt   = (cur_r < 0) ^ (rd_s < 0);
              it_nxt    = '0;
              state_nxt = ST_DIV;
            end
          end
          MODE_MAX: nv_nxt = (cur_r > rd_s) ? cur_r : rd_s;
          MODE_MIN: nv_nxt = (cur_r < rd_s) ? cur_r : rd_s;
          MODE_SET: nv_nxt = rd_s;
          default:  nv_nxt = cur_r;
        endcase
      end
      ST_BMUL: begin
        sres      = sat32(SAT_W'(prod_sh));
        nv_nxt    = sres.val;
        sat_nxt   = sat_r | sres.hit;
        state_nxt = ST_INTERP;
      end
      ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        drem_nxt = ge ? 32'(drem2 - {1'b0, dvs_r}) : drem2[31:0];
        quo_nxt  = {quo_r[DW-2:0], ge};
        dvd_nxt  = dvd_r << 1;
        it_nxt   = it_r + IT_W'(1);
        if (it_r == IT_W'(DW - 1)) begin
          state_nxt = ST_DIVF;
        end
      end
      ST_DIVF: begin
        sres      = sat32(SAT_W'(qs));
        nv_nxt    = sres.val;
        sat_nxt   = sat_r | sres.hit;
        state_nxt = ST_INTERP;
      end
      ST_INTERP: begin
        state_nxt = ST_IACC;
      end
      ST_IACC: begin
        sres      = sat32(SAT_W'(cur_r) + SAT_W'(prod_sh));
        cur_nxt   = sres.val;
        sat_nxt   = sat_r | sres.hit;
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        if ((s_r + CNT_W'(1)) == n_r) begin
          state_nxt = ST_DONE;
        end else begin
          s_nxt     = s_r + CNT_W'(1);
          base_nxt  = base_r + AW'(WORDS_PER_SHAPE);
          state_nxt = ST_CTL;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = cur_r;
          out_st_nxt    = div0_r ? STAT_DIV0 : (sat_r ? STAT_SAT : STAT_OK);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        count_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_val_r <= out_val_nxt;
    out_st_r  <= out_st_nxt;
    pos_r     <= pos_nxt;
    loc_r     <= loc_nxt;
    cur_r     <= cur_nxt;
    nv_r      <= nv_nxt;
    acc_r     <= acc_nxt;
    prod_r    <= mul_a * mul_b;
    sq_r      <= sq_nxt;
    ctl_r     <= ctl_nxt;
    alpha_r   <= alpha_nxt;
    tmp_r     <= tmp_nxt;
    sat_r     <= sat_nxt;
    div0_r    <= div0_nxt;
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    s_r       <= s_nxt;
    n_r       <= n_nxt;
    base_r    <= base_nxt;
    rad_r     <= rad_nxt;
    root_r    <= root_nxt;
    rem_r     <= rem_nxt;
    it_r      <= it_nxt;
    dvd_r     <= dvd_nxt;
    quo_r     <= quo_nxt;
    dvs_r     <= dvs_nxt;
    drem_r    <= drem_nxt;
    neg_r     <= neg_nxt;
  end

  `VFBE_ASSERT_NXT(a_eval_leaves_idle, in_xfer && (in_ch.op == OP_EVAL), state_r != ST_IDLE)
  `VFBE_ASSERT_IMP(a_status_legal, out_valid_r, out_st_r != 2'd3)
  `VFBE_ASSERT_IMP(a_dist_in_unit, state_r == ST_AM, root_r <= ONE_W[F:0])
  `VFBE_ASSERT_IMP(a_alpha_in_unit, state_r == ST_INTERP, alpha_r <= ONE_W[F:0])

endmodule

>>> sv/vfbe_shape_mem.sv
// Shape table memory: one write port, one registered read port.
module vfbe_shape_mem #(
  parameter int DEPTH = 640,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sim/volume_field_blend_evaluator_tb.sv
// Self-checking testbench for the volume field blend evaluator: directed and random items.
module volume_field_blend_evaluator_tb import vfbe_pkg::*;;

  localparam int NSHAPES = 32;
  localparam int ONE_Q = 32'sh0001_0000;
  localparam int IDLE_LIMIT = 60000;
  localparam int SETTLE = 30;

  logic clk = 1'b0;
  logic rst_n;

  vfbe_in_if  in_if();
  vfbe_out_if out_if();
  vfbe_cfg_if cfg_if();

  volume_field_blend_evaluator uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source), .cfg_ch(cfg_if.sink)
  );

  always #5 clk = ~clk;

  // Shadow copy of the shape table and the shape count
  logic [3:0]         tbl_ctl[NSHAPES];
  logic signed [31:0] tbl_val[NSHAPES];
  logic signed [31:0] tbl_mat[NSHAPES][12];
  logic signed [31:0] tbl_fade[NSHAPES][6];
  bit                 tbl_loaded[NSHAPES];
  int unsigned        active_count;

  typedef struct {
    logic signed [31:0] field;
    logic [1:0]         status;
  } field_result_t;

  field_result_t pending_fields[$];

  int errors = 0;
  int n_results = 0;
  int n_loads = 0;
  int n_evals = 0;
  int n_cfg = 0;
  int idle_cycles = 0;
  int out_stall = 0;
  bit no_idle = 1'b0;

  function automatic longint clamp32(longint v, inout bit hit);
    if (v > 64'sh7FFF_FFFF) begin
      hit = 1'b1;
      return 64'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      hit = 1'b1;
      return -64'sh8000_0000;
    end
    return v;
  endfunction

  function automatic longint mulq(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v < 0) return 0;
    if (v > ONE_Q) return ONE_Q;
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic field_result_t blend_field(logic signed [31:0] px, logic signed [31:0] py,
                                                logic signed [31:0] pz, logic signed [31:0] iv);
    field_result_t r;
    longint p[3], loc[3], a[3];
    longint cur, acc, alpha, nv, sval, dist_q;
    longint unsigned sq;
    int n;
    bit sat, div0, dummy, in_shape;
    logic [3:0] ctl;
    p[0] = px; p[1] = py; p[2] = pz;
    cur = iv;
    sat = 0; div0 = 0; dummy = 0;
    n = (active_count > NSHAPES) ? NSHAPES : active_count;
    for (int s = 0; s < n; s++) begin
      for (int row = 0; row < 3; row++) begin
        acc = tbl_mat[s][row*4+3];
        for (int c = 0; c < 3; c++) acc += mulq(tbl_mat[s][row*4+c], p[c]);
        loc[row] = clamp32(acc, dummy);
        a[row] = (loc[row] < 0) ? -loc[row] : loc[row];
      end
      ctl = tbl_ctl[s];
      if (!ctl[0]) begin
        sq = 0;
        for (int row = 0; row < 3; row++) sq += longint'(a[row]) * longint'(a[row]);
        if (sq > 64'h1_0000_0000) continue;
        dist_q = floor_sqrt(sq);
        alpha = clamp_unit(mulq(dist_q, tbl_fade[s][0]) + tbl_fade[s][3]);
      end else begin
        in_shape = 1'b1;
        for (int row = 0; row < 3; row++) if (a[row] > ONE_Q) in_shape = 1'b0;
        if (!in_shape) continue;
        alpha = ONE_Q;
        for (int row = 0; row < 3; row++)
          alpha = mulq(alpha, clamp_unit(mulq(a[row], tbl_fade[s][row]) + tbl_fade[s][row+3]));
      end
      sval = tbl_val[s];
      case (ctl[3:1])
        MODE_ADD: nv = clamp32(cur + sval, sat);
        MODE_SUB: nv = clamp32(cur - sval, sat);
        MODE_MUL: nv = clamp32(mulq(cur, sval), sat);
        MODE_DIV: begin
          if (sval == 0) begin
            div0 = 1'b1;
            nv = cur;
          end else begin
            nv = clamp32((cur * ONE_Q) / sval, sat);
          end
        end
        MODE_MAX: nv = (cur > sval) ? cur : sval;
        MODE_MIN: nv = (cur < sval) ? cur : sval;
        MODE_SET: nv = sval;
        default:  nv = cur;
      endcase
      cur = clamp32(cur + mulq(nv - cur, alpha), sat);
    end
    r.field = cur[31:0];
    r.status = div0 ? STAT_DIV0 : (sat ? STAT_SAT : STAT_OK);
    return r;
  endfunction

  function automatic void store_word(logic [4:0] si, logic [4:0] wi, logic signed [31:0] wv);
    if (wi > W_LAST) return;
    if (wi == W_CTL) tbl_ctl[si] = wv[3:0];
    else if (wi == W_VAL) tbl_val[si] = wv;
    else if (wi < W_SCALE) tbl_mat[si][wi - W_MAT] = wv;
    else tbl_fade[si][wi - W_SCALE] = wv;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : int'($urandom_range(0, 6));
  endfunction

  task automatic report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // Send one item; valid stays high after the transfer so back-to-back items need no drop
  task automatic send_item(logic op, logic [4:0] si, logic [4:0] wi, logic signed [31:0] wv,
                           logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [31:0] pz, logic signed [31:0] iv);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.shape_index <= si;
    in_if.word_index <= wi;
    in_if.word_value <= wv;
    in_if.pos_x <= px;
    in_if.pos_y <= py;
    in_if.pos_z <= pz;
    in_if.initial_value <= iv;
    do @(posedge clk); while (!in_if.ready);
    if (op == OP_EVAL) begin
      pending_fields.push_back(blend_field(px, py, pz, iv));
      n_evals++;
    end else begin
      store_word(si, wi, wv);
      n_loads++;
    end
  endtask

  task automatic load_word(logic [4:0] si, logic [4:0] wi, logic signed [31:0] wv);
    send_item(OP_LOAD, si, wi, wv, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic evaluate(logic signed [31:0] px, logic signed [31:0] py,
                          logic signed [31:0] pz, logic signed [31:0] iv);
    send_item(OP_EVAL, 5'($urandom), 5'($urandom), $urandom, px, py, pz, iv);
  endtask

  // Drain all results, then let any trailing load finish before touching the register
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_fields.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_count(int unsigned value);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value[COUNT_W-1:0];
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    active_count = value[COUNT_W-1:0];
    n_cfg++;
  endtask

  function automatic logic signed [31:0] rand_q(int lo_milli, int hi_milli);
    longint v;
    v = $urandom_range(0, hi_milli - lo_milli);
    v = ((v + lo_milli) * ONE_Q) / 1000;
    return v[31:0];
  endfunction

  // Mostly well-shaped words so points fall inside shapes; now and then raw bits
  function automatic logic signed [31:0] rand_word(logic [4:0] wi);
    logic signed [31:0] v;
    if ($urandom_range(0, 9) == 0) return $urandom;
    case (wi) inside
      W_CTL: v = {$urandom_range(0, 1) ? 28'($urandom) : 28'd0, 4'($urandom)};
      W_VAL: v = ($urandom_range(0, 7) == 0) ? 32'sd0 : rand_q(-4000, 4000);
      W_MAT + 0, W_MAT + 5, W_MAT + 10: v = rand_q(-2000, 2000);
      W_MAT + 3, W_MAT + 7, W_MAT + 11: v = rand_q(-500, 500);
      W_SCALE, W_SCALE + 1, W_SCALE + 2: v = rand_q(-2000, 2000);
      W_BIAS, W_BIAS + 1, W_BIAS + 2: v = rand_q(-500, 1500);
      default: v = rand_q(-250, 250);
    endcase
    return v;
  endfunction

  task automatic load_shape(int s);
    for (int w = 0; w <= W_LAST; w++) load_word(5'(s), 5'(w), rand_word(5'(w)));
    tbl_loaded[s] = 1'b1;
  endtask

  task automatic load_fixed_shape(int s, logic [3:0] ctl, logic signed [31:0] value,
                                  logic signed [31:0] fscale, logic signed [31:0] fbias);
    load_word(5'(s), W_CTL, 32'(ctl));
    load_word(5'(s), W_VAL, value);
    for (int k = 0; k < 12; k++)
      load_word(5'(s), W_MAT + 5'(k), (k == 0 || k == 5 || k == 10) ? ONE_Q : 0);
    for (int k = 0; k < 3; k++) load_word(5'(s), W_SCALE + 5'(k), fscale);
    for (int k = 0; k < 3; k++) load_word(5'(s), W_BIAS + 5'(k), fbias);
    tbl_loaded[s] = 1'b1;
  endtask

  // Count zero: value passes through untouched, extremes of positions and start value
  task automatic test_empty_table();
    write_count(0);
    evaluate(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh7FFF_FFFF);
    evaluate(32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF, 32'sh8000_0000);
    evaluate(32'sh0, 32'sh0, 32'sh7FFF_FFFF, 32'sh0);
  endtask

  // One unit box at the origin with full alpha; step through every blend mode
  task automatic test_blend_modes();
    logic [2:0] modes[8] = '{MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV,
                             MODE_MAX, MODE_MIN, MODE_SET, MODE_KEEP};
    load_fixed_shape(0, {MODE_ADD, 1'b1}, 32'sh7FFF_0000, 0, ONE_Q);
    write_count(1);
    foreach (modes[i]) begin
      load_word(0, W_CTL, {28'hFFF_FFF0 ^ 28'(i), modes[i], 1'b1});
      evaluate(0, 0, 0, 32'sh7000_0000);
      evaluate(ONE_Q, -ONE_Q, ONE_Q, -32'sh0003_8000);
    end
    // divide by a zero value, and writes past the last word that must be dropped
    load_word(0, W_VAL, 0);
    load_word(0, W_CTL, 32'({MODE_DIV, 1'b1}));
    load_word(0, 5'd20, 32'sh1234_5678);
    load_word(5'd31, 5'd31, 32'shFFFF_FFFF);
    evaluate(0, 0, 0, ONE_Q);
  endtask

  // Unit sphere with a radial fade, points inside, on and outside the surface
  task automatic test_sphere_fade();
    load_fixed_shape(0, {MODE_SET, 1'b0}, 32'sh0005_0000, -ONE_Q, ONE_Q);
    evaluate(0, 0, 0, 0);
    evaluate(32'sh0000_8000, 0, 0, 0);
    evaluate(ONE_Q, 0, 0, 0);
    evaluate(0, 32'sh0000_C000, 32'sh0000_C000, 0);
  endtask

  // Random phases under several counts, extremes included
  task automatic test_random_phases();
    int unsigned counts[10] = '{3, 1, 8, 0, 17, 2, 63, 5, 32, 40};
    int unsigned n, items;
    logic signed [31:0] px, py, pz, iv;
    foreach (counts[i]) begin
      n = (counts[i] > NSHAPES) ? NSHAPES : counts[i];
      for (int s = 0; s < n; s++) if (!tbl_loaded[s]) load_shape(s);
      write_count(counts[i]);
      no_idle = (i % 4 == 3);
      items = (n > 16) ? 12 : 25;
      repeat (items) begin
        case ($urandom_range(0, 9)) inside
          [0:4]: begin
            if ($urandom_range(0, 7) == 0) begin
              px = $urandom; py = $urandom; pz = $urandom; iv = $urandom;
            end else begin
              px = rand_q(-2000, 2000); py = rand_q(-2000, 2000);
              pz = rand_q(-2000, 2000); iv = rand_q(-8000, 8000);
            end
            evaluate(px, py, pz, iv);
          end
          5: load_word(5'($urandom), 5'($urandom_range(20, 31)), $urandom);
          default: begin
            int s;
            logic [4:0] w;
            s = $urandom_range(0, NSHAPES - 1);
            w = 5'($urandom_range(0, W_LAST));
            if (tbl_loaded[s]) load_word(5'(s), w, rand_word(w));
            else load_shape(s);
          end
        endcase
      end
    end
    no_idle = 1'b0;
  endtask

  // Result side: random stall after each transfer, checks, and the idle watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_stall <= 0;
      idle_cycles <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        int gap;
        field_result_t exp_r;
        if (pending_fields.size() == 0) begin
          report($sformatf("unexpected result %h status %0d", out_if.field_value, out_if.status));
        end else begin
          exp_r = pending_fields.pop_front();
          if (out_if.field_value !== exp_r.field)
            report($sformatf("field_value %h, predicted %h", out_if.field_value, exp_r.field));
          if (out_if.status !== exp_r.status)
            report($sformatf("status %0d, predicted %0d", out_if.status, exp_r.status));
        end
        n_results++;
        gap = draw_gap();
        out_stall <= gap;
        out_if.ready <= (gap == 0);
      end else if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_if.ready <= (out_stall == 1);
      end else begin
        out_if.ready <= 1'b1;
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.op <= OP_LOAD;
    in_if.shape_index <= '0;
    in_if.word_index <= '0;
    in_if.word_value <= '0;
    in_if.pos_x <= '0;
    in_if.pos_y <= '0;
    in_if.pos_z <= '0;
    in_if.initial_value <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    active_count = 0;
    foreach (tbl_loaded[s]) tbl_loaded[s] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_blend_modes();
    test_sphere_fade();
    test_random_phases();

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d loads, %0d evaluations, %0d results, %0d count writes",
             n_loads, n_evals, n_results, n_cfg);
    $display("modes, sphere and box fades, divide by zero, saturation, counts 0 to 63");
    if (errors == 0 && pending_fields.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_fields.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
